// ===== rtl/tets_pkg.sv =====
`timescale 1ns / 1ps

package tets_pkg;

    // Field widths of the result beat
    localparam int RUN_W   = 16;
    localparam int TOTAL_W = 32;

    // Character codes handled specially
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef logic [7:0] t_byte;

    // One result beat
    typedef struct packed {
        logic [RUN_W-1:0]   space_run;
        t_byte              out_byte;
        logic               byte_valid;
        logic               end_of_blob;
        logic [TOTAL_W-1:0] total_length;
        logic               overflow;
    } t_out_beat;

endpackage

// ===== rtl/tets_if.sv =====
`timescale 1ns / 1ps

// Input channel: one raw text byte per beat
interface tets_in_if;
    logic               valid;
    logic               ready;
    tets_pkg::t_byte    in_byte;
    logic               last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// Output channel: held spaces plus at most one byte per beat
interface tets_out_if;
    logic                           valid;
    logic                           ready;
    logic [tets_pkg::RUN_W-1:0]     space_run;
    tets_pkg::t_byte                out_byte;
    logic                           byte_valid;
    logic                           end_of_blob;
    logic [tets_pkg::TOTAL_W-1:0]   total_length;
    logic                           overflow;

    modport source (output valid, output space_run, output out_byte, output byte_valid,
                    output end_of_blob, output total_length, output overflow,
                    input ready);
    modport sink   (input valid, input space_run, input out_byte, input byte_valid,
                    input end_of_blob, input total_length, input overflow,
                    output ready);
endinterface

// ===== rtl/tab_expand_trailing_space_strip.sv =====
`timescale 1ns / 1ps

// Whitespace cleaner for a text byte stream. Each input beat carries one byte;
// spaces and tabs (expanded to the next TAB_STOP column) are only counted and
// produce no beat, any other byte produces one beat carrying the held space
// count followed by that byte, and a newline drops the held spaces. The last
// byte of a blob always produces a beat with end_of_blob set and the blob's
// cleaned length; the block then returns to its reset state for the next blob.
// The held count saturates at min(2^HELD_SPACE_BITS-1, 65535) and sets overflow.
// Throughput is one byte per clock while the skid register is empty: the state
// update is a single small add and compare, and a two-entry output stage (result
// register plus skid register) keeps input ready independent of the current
// output ready. A result beat is registered in the result or skid register.
module tab_expand_trailing_space_strip #(
    parameter int TAB_STOP        = 4,
    parameter int HELD_SPACE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tets_in_if.sink             i_in,
    tets_out_if.source          o_out
);
    import tets_pkg::*;

    localparam int HW = (HELD_SPACE_BITS > RUN_W) ? RUN_W : HELD_SPACE_BITS;
    localparam int CW = $clog2(TAB_STOP);
    localparam int NW = $clog2(TAB_STOP + 1);
    localparam int SW = ((HW > NW) ? HW : NW) + 1;
    localparam logic [SW-1:0] HeldLim  = SW'((33'd1 << HW) - 33'd1);
    localparam logic [CW-1:0] PhaseTop = CW'(TAB_STOP - 1);

    // State
    logic [CW-1:0]      r_phase, n_phase;
    logic [HW-1:0]      r_held, n_held;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_sat, n_sat;

    // Output stage
    logic      r_main_valid, r_skid_valid;
    t_out_beat r_main, r_skid;

    logic               accept, emit, take;
    logic [CW-1:0]      phase_adv;
    logic [NW-1:0]      add_n;
    logic               do_add;
    logic [SW-1:0]      held_sum;
    logic [HW-1:0]      held_added;
    logic               sat_now;
    logic [RUN_W-1:0]   run;
    logic               valid_b;
    t_out_beat          beat;

    assign accept = i_in.valid && i_in.ready;
    assign take   = r_main_valid && o_out.ready;

    assign phase_adv = (r_phase == PhaseTop) ? '0 : r_phase + CW'(1);

    // Spaces added by this byte: one for a space, up to the next stop for a tab
    assign do_add = (i_in.in_byte == CHAR_SPACE) || (i_in.in_byte == CHAR_TAB);
    assign add_n  = (i_in.in_byte == CHAR_TAB) ? (NW'(TAB_STOP) - NW'(r_phase)) : NW'(1);

    // Held space accumulation with saturation
    assign held_sum   = SW'(r_held) + SW'(add_n);
    assign sat_now    = do_add && (held_sum > HeldLim);
    assign held_added = sat_now ? HW'(HeldLim) : held_sum[HW-1:0];

    // Byte classification and next state
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_sat   = r_sat;
        emit    = 1'b0;
        run     = '0;
        valid_b = 1'b0;
        case (i_in.in_byte)
            CHAR_SPACE: begin
                n_held  = held_added;
                n_sat   = r_sat | sat_now;
                n_phase = phase_adv;
            end
            CHAR_TAB: begin
                n_held  = held_added;
                n_sat   = r_sat | sat_now;
                n_phase = '0;
            end
            CHAR_NL: begin
                n_held  = '0;
                n_phase = '0;
                emit    = 1'b1;
                valid_b = 1'b1;
            end
            default: begin
                emit    = 1'b1;
                run     = RUN_W'(r_held);
                valid_b = 1'b1;
                n_held  = '0;
                n_phase = phase_adv;
            end
        endcase
        // Final flush of held spaces
        if (i_in.last_byte && !emit) begin
            emit   = 1'b1;
            run    = RUN_W'(n_held);
            n_held = '0;
        end
        n_total = emit ? (r_total + TOTAL_W'(run) + TOTAL_W'(valid_b)) : r_total;

        beat.space_run    = run;
        beat.out_byte     = valid_b ? i_in.in_byte : '0;
        beat.byte_valid   = valid_b;
        beat.end_of_blob  = i_in.last_byte;
        beat.total_length = i_in.last_byte ? n_total : '0;
        beat.overflow     = n_sat;
    end

    // State registers; cleared after the last byte of a blob
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_held  <= '0;
            r_total <= '0;
            r_sat   <= 1'b0;
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_phase <= '0;
                r_held  <= '0;
                r_total <= '0;
                r_sat   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_total <= n_total;
                r_sat   <= n_sat;
            end
        end
    end

    // Result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (take) begin
                if (r_skid_valid) begin
                    r_main       <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (accept && emit) begin
                    r_main <= beat;
                end else begin
                    r_main_valid <= 1'b0;
                end
            end else if (accept && emit) begin
                if (!r_main_valid) begin
                    r_main       <= beat;
                    r_main_valid <= 1'b1;
                end else begin
                    r_skid       <= beat;
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    assign i_in.ready         = !r_skid_valid;
    assign o_out.valid        = r_main_valid;
    assign o_out.space_run    = r_main.space_run;
    assign o_out.out_byte     = r_main.out_byte;
    assign o_out.byte_valid   = r_main.byte_valid;
    assign o_out.end_of_blob  = r_main.end_of_blob;
    assign o_out.total_length = r_main.total_length;
    assign o_out.overflow     = r_main.overflow;

endmodule
